/* hw/rtl/dsa_pkg.sv */
`timescale 1ns / 1ps

package dsa_pkg;

	localparam int SLOTS    = 1024;
	localparam int SLOT_W   = 10;
	localparam int CNT_W    = 11;
	localparam int KEY_W    = 64;
	localparam int STATUS_W = 3;

	// action codes
	localparam logic ACT_REGISTER = 1'b0;
	localparam logic ACT_RELEASE  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] RS_NEW      = 3'd0;
	localparam logic [STATUS_W-1:0] RS_HELD     = 3'd1;
	localparam logic [STATUS_W-1:0] RS_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] RS_REJECT   = 3'd3;
	localparam logic [STATUS_W-1:0] RS_RELEASED = 3'd4;
	localparam logic [STATUS_W-1:0] RS_IGNORED  = 3'd5;

	typedef struct packed {
		logic              action;
		logic [KEY_W-1:0]  resource_key;
		logic [SLOT_W-1:0] release_slot;
	} dsa_request_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   granted_slot;
		logic [STATUS_W-1:0] status;
	} dsa_result_t;

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_HIT,
		SEL_POP,
		SEL_REL
	} dsa_slot_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic                load;
		logic                clr;
		logic                scan_init;
		logic                scan;
		logic                pop_rd;
		logic                grant;
		logic                rel_rd;
		logic                release_op;
		logic                emit;
		logic [STATUS_W-1:0] status;
		dsa_slot_sel_t       slot_sel;
	} dsa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic enabled;
		logic is_release;
		logic key_null;
		logic slot_oob;
		logic hit;
		logic scan_end;
		logic full;
		logic rd_zero;
	} dsa_sts_t;

endpackage

/* hw/rtl/dsa_datapath.sv */
`timescale 1ns / 1ps

module dsa_datapath import dsa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  dsa_cmd_t     cmd,
	input  dsa_request_t request,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	output dsa_sts_t     sts,
	output logic         done,
	output dsa_result_t  result
);

	logic [KEY_W-1:0]  key_mem [SLOTS];
	logic [SLOT_W-1:0] stack_mem [SLOTS];

	logic              enable_q;
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] clr_idx_q;
	logic [CNT_W-1:0]  scan_idx_q;
	logic              scan_vld_s1;
	logic [SLOT_W-1:0] scan_idx_s1;
	logic [KEY_W-1:0]  key_rd_s1;
	logic              action_q;
	logic [KEY_W-1:0]  key_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] pop_slot_q;
	logic              done_q;
	dsa_result_t       result_q;

	logic              all_issued;
	logic              scan_issue;
	logic              key_we;
	logic [SLOT_W-1:0] key_waddr;
	logic [KEY_W-1:0]  key_wdata;
	logic [SLOT_W-1:0] key_raddr;
	logic              key_re;
	logic              push;
	logic              stack_we;
	logic [SLOT_W-1:0] stack_waddr;
	logic [SLOT_W-1:0] stack_wdata;
	logic [CNT_W-1:0]  count_m1;
	logic [SLOT_W-1:0] slot_mux;

	assign all_issued = (scan_idx_q == CNT_W'(SLOTS));
	assign scan_issue = cmd.scan && !all_issued;
	assign count_m1   = count_q - CNT_W'(1);
	assign push       = cmd.release_op && (count_q < CNT_W'(SLOTS));

	always_comb begin
		key_we    = cmd.clr || cmd.grant || cmd.release_op;
		key_waddr = clr_idx_q;
		key_wdata = '0;
		if (cmd.grant) begin
			key_waddr = pop_slot_q;
			key_wdata = key_q;
		end else if (cmd.release_op) begin
			key_waddr = slot_q;
		end
	end

	assign key_re    = scan_issue || cmd.rel_rd;
	assign key_raddr = cmd.rel_rd ? slot_q : scan_idx_q[SLOT_W-1:0];

	assign stack_we    = cmd.clr || push;
	assign stack_waddr = cmd.clr ? clr_idx_q : count_q[SLOT_W-1:0];
	assign stack_wdata = cmd.clr ? clr_idx_q : slot_q;

	// memories
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_waddr] <= key_wdata;
		end
		if (key_re) begin
			key_rd_s1 <= key_mem[key_raddr];
		end
		if (stack_we) begin
			stack_mem[stack_waddr] <= stack_wdata;
		end
		if (cmd.pop_rd) begin
			pop_slot_q <= stack_mem[count_m1[SLOT_W-1:0]];
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= request.action;
			key_q    <= request.resource_key;
			slot_q   <= request.release_slot;
		end
		if (scan_issue) begin
			scan_idx_s1 <= scan_idx_q[SLOT_W-1:0];
		end
		if (cmd.emit) begin
			result_q.status <= cmd.status;
			result_q.granted_slot <= slot_mux;
		end
	end

	always_comb begin
		case (cmd.slot_sel)
			SEL_HIT: slot_mux = scan_idx_s1;
			SEL_POP: slot_mux = pop_slot_q;
			SEL_REL: slot_mux = slot_q;
			default: slot_mux = '0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b1;
			count_q     <= CNT_W'(SLOTS);
			clr_idx_q   <= '0;
			scan_idx_q  <= '0;
			scan_vld_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			if (cmd.clr) begin
				clr_idx_q <= clr_idx_q + SLOT_W'(1);
			end
			if (cmd.scan_init) begin
				scan_idx_q <= '0;
			end else if (scan_issue) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
			scan_vld_s1 <= scan_issue;
			if (cmd.grant) begin
				count_q <= count_m1;
			end else if (push) begin
				count_q <= count_q + CNT_W'(1);
			end
			done_q <= cmd.emit;
		end
	end

	always_comb begin
		sts.clr_last   = (clr_idx_q == SLOT_W'(SLOTS - 1));
		sts.enabled    = enable_q;
		sts.is_release = (action_q == ACT_RELEASE);
		sts.key_null   = (key_q == '0);
		sts.slot_oob   = ({1'b0, slot_q} >= CNT_W'(SLOTS));
		sts.hit        = scan_vld_s1 && (key_rd_s1 == key_q);
		sts.scan_end   = scan_vld_s1 && (scan_idx_s1 == SLOT_W'(SLOTS - 1));
		sts.full       = (count_q == '0) || (count_q > CNT_W'(SLOTS));
		sts.rd_zero    = (key_rd_s1 == '0);
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* hw/rtl/dsa_ctrl.sv */
`timescale 1ns / 1ps

module dsa_ctrl import dsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dsa_sts_t sts,
	output dsa_cmd_t cmd,
	output logic     busy
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_POP_RD,
		S_POP_WR,
		S_REL_RD,
		S_REL_CHK
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.status   = RS_REJECT;
		cmd.slot_sel = SEL_ZERO;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!sts.enabled) begin
					cmd.emit   = 1'b1;
					cmd.status = RS_REJECT;
					state_d    = S_IDLE;
				end else if (sts.is_release) begin
					if (sts.slot_oob) begin
						cmd.emit   = 1'b1;
						cmd.status = RS_IGNORED;
						state_d    = S_IDLE;
					end else begin
						state_d = S_REL_RD;
					end
				end else if (sts.key_null) begin
					cmd.emit   = 1'b1;
					cmd.status = RS_REJECT;
					state_d    = S_IDLE;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.emit     = 1'b1;
					cmd.status   = RS_HELD;
					cmd.slot_sel = SEL_HIT;
					state_d      = S_IDLE;
				end else if (sts.scan_end) begin
					if (sts.full) begin
						cmd.emit   = 1'b1;
						cmd.status = RS_FULL;
						state_d    = S_IDLE;
					end else begin
						state_d = S_POP_RD;
					end
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_POP_RD: begin
				cmd.pop_rd = 1'b1;
				state_d    = S_POP_WR;
			end
			S_POP_WR: begin
				cmd.grant    = 1'b1;
				cmd.emit     = 1'b1;
				cmd.status   = RS_NEW;
				cmd.slot_sel = SEL_POP;
				state_d      = S_IDLE;
			end
			S_REL_RD: begin
				cmd.rel_rd = 1'b1;
				state_d    = S_REL_CHK;
			end
			S_REL_CHK: begin
				cmd.emit = 1'b1;
				if (sts.rd_zero) begin
					cmd.status = RS_IGNORED;
				end else begin
					cmd.release_op = 1'b1;
					cmd.status     = RS_RELEASED;
					cmd.slot_sel   = SEL_REL;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

/* hw/rtl/dedup_slot_allocator.sv */
`timescale 1ns / 1ps
// Channel   | Ports                     | Handshake
// ----------+---------------------------+-------------------------------------
// request   | start, busy, request      | taken on an edge with start & !busy
// result    | done, result              | one-cycle strobe, always taken
// config    | cfg_we, cfg_wdata         | alloc_enable written when cfg_we high
//
// After reset a clearing pass empties the key table and loads the
// free stack with 0..1023; busy stays high throughout it.
// A reject or out-of-range release is answered at decode; a release first reads
// and checks its table entry; a register request scans the table, stopping at a
// hit, and a new grant then pops the free stack. The key lookup reads the table
// one entry per cycle from a single read port. The receiver cannot stall results.

module dedup_slot_allocator import dsa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  dsa_request_t request,
	output logic         done,
	output dsa_result_t  result,
	input  logic         cfg_we,
	input  logic         cfg_wdata
);

	dsa_cmd_t cmd;
	dsa_sts_t sts;

	// sequencing: clear pass, decode, table scan, stack pop / release check
	dsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// key table, free stack, free count, request and result registers
	dsa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sts       (sts),
		.done      (done),
		.result    (result)
	);

endmodule

/* verif/dedup_slot_allocator_tb.sv */
`timescale 1ns / 1ps

module dedup_slot_allocator_tb;
	import dsa_pkg::*;

	localparam int          RANDOM_PER_PHASE = 193;
	localparam int          MAX_GAP          = 12;
	// a new grant or a full answer scans every slot
	localparam int          SETTLE_CYCLES    = SLOTS + 76;
	localparam int          MAX_PRINTED      = 100;
	// slowest correct run: ~1650 requests, each a full table scan plus its send gap, at 20 ns a clock, taken ~4x
	localparam int unsigned TIMEOUT_NS       = 150_000_000;

	// directed plan: a row is a request (typed or predicted result), an enable
	// write, or a fill of the table up to capacity
	typedef enum {
		ROW_PREDICT,
		ROW_TYPED,
		ROW_ENABLE_ON,
		ROW_ENABLE_OFF,
		ROW_FILL
	} row_kind_t;

	typedef struct {
		row_kind_t    kind;
		dsa_request_t req;
		dsa_result_t  want;
	} stim_row_t;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         start     = 1'b0;
	logic         busy;
	dsa_request_t request   = '0;
	logic         done;
	dsa_result_t  result;
	logic         cfg_we    = 1'b0;
	logic         cfg_wdata = 1'b1;

	// allocator state as the testbench sees it
	logic [KEY_W-1:0]  model_keys  [SLOTS];
	logic [SLOT_W-1:0] model_stack [SLOTS];
	int                model_free;
	bit                model_enable;

	dsa_result_t awaited_results [$];
	stim_row_t   stim_plan [$];
	dsa_result_t oldest;
	int          sender_idle_pct;
	int          requests_sent;
	int          results_checked;
	int          mismatch_count;
	int          status_tally [8];

	dedup_slot_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("MISMATCH @%0t result %0d: %s", $time, results_checked, what);
	endtask

	// Lookup first, then pop from the LIFO free stack. Release of an empty slot
	// is ignored, so a slot never lands on the stack twice.
	function automatic dsa_result_t predict_slot_result(input dsa_request_t req);
		dsa_result_t res;
		int          i;
		int          s;
		res.granted_slot = '0;
		res.status       = RS_REJECT;
		if (!model_enable)
			return res;
		if (req.action == ACT_REGISTER) begin
			if (req.resource_key == '0)
				return res;
			for (i = 0; i < SLOTS; i++) begin
				if (model_keys[i] == req.resource_key) begin
					res.granted_slot = SLOT_W'(i);
					res.status       = RS_HELD;
					return res;
				end
			end
			res.status = RS_FULL;
			if (model_free == 0)
				return res;
			model_free--;
			s                = model_stack[model_free];
			model_keys[s]    = req.resource_key;
			res.granted_slot = SLOT_W'(s);
			res.status       = RS_NEW;
			return res;
		end
		res.status = RS_IGNORED;
		if (model_keys[req.release_slot] == '0)
			return res;
		model_keys[req.release_slot] = '0;
		if (model_free < SLOTS) begin
			model_stack[model_free] = req.release_slot;
			model_free++;
		end
		res.granted_slot = req.release_slot;
		res.status       = RS_RELEASED;
		return res;
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		do
			k = {$urandom, $urandom};
		while (k == '0);
		return k;
	endfunction

	// random slot that is occupied (or empty); -1 if there is none
	function automatic int pick_slot(input bit occupied);
		int base;
		int k;
		int s;
		base = $urandom_range(SLOTS - 1);
		for (k = 0; k < SLOTS; k++) begin
			s = (base + k) % SLOTS;
			if ((model_keys[s] != '0) == occupied)
				return s;
		end
		return -1;
	endfunction

	// Mostly well-formed traffic: unseen keys, keys already held, releases of
	// live slots. The rest is null keys, releases of empty slots and noise.
	// Unused fields always carry random bits.
	function automatic dsa_request_t random_request();
		dsa_request_t req;
		int           roll;
		int           s;
		req.action       = ACT_REGISTER;
		req.resource_key = fresh_key();
		req.release_slot = SLOT_W'($urandom_range(SLOTS - 1));
		roll             = $urandom_range(99);
		if (roll >= 30 && roll < 55) begin
			s = pick_slot(1'b1);
			if (s >= 0)
				req.resource_key = model_keys[s];
		end else if (roll >= 55 && roll < 85) begin
			req.action = ACT_RELEASE;
			s          = pick_slot(1'b1);
			if (s >= 0)
				req.release_slot = SLOT_W'(s);
		end else if (roll >= 85 && roll < 92) begin
			req.action = ACT_RELEASE;
			s          = pick_slot(1'b0);
			if (s >= 0)
				req.release_slot = SLOT_W'(s);
		end else if (roll >= 92 && roll < 96) begin
			req.resource_key = '0;
		end else if (roll >= 96) begin
			req.action = ACT_RELEASE;
		end
		return req;
	endfunction

	function automatic void add_row(input row_kind_t kind, input logic action,
			input logic [KEY_W-1:0] key, input logic [SLOT_W-1:0] slot,
			input logic [SLOT_W-1:0] want_slot, input logic [STATUS_W-1:0] want_status);
		stim_row_t r;
		r.kind              = kind;
		r.req.action        = action;
		r.req.resource_key  = key;
		r.req.release_slot  = slot;
		r.want.granted_slot = want_slot;
		r.want.status       = want_status;
		stim_plan.insert(stim_plan.size(), r);
	endfunction

	// Present one request after a random gap and hold it until busy is low at
	// an edge. start stays high when the next request follows with no gap.
	task automatic issue_request(input dsa_request_t req, input bit typed,
			input dsa_result_t typed_want);
		int          gap;
		dsa_result_t predicted;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= req;
		do
			@(posedge clk);
		while (busy);
		predicted = predict_slot_result(req);
		awaited_results.insert(awaited_results.size(), typed ? typed_want : predicted);
		requests_sent++;
	endtask

	// drop start and wait for every result and for busy to fall
	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0 || busy);
	endtask

	task automatic write_enable(input bit value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we       <= 1'b0;
		model_enable  = value;
	endtask

	// results are a one-cycle strobe; check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			status_tally[result.status]++;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result slot %0d status %0d",
					result.granted_slot, result.status));
			end else begin
				oldest = awaited_results.pop_front();
				if (result.granted_slot !== oldest.granted_slot)
					report_mismatch($sformatf("granted_slot %0d, wanted %0d",
						result.granted_slot, oldest.granted_slot));
				if (result.status !== oldest.status)
					report_mismatch($sformatf("status %0d, wanted %0d",
						result.status, oldest.status));
			end
			results_checked++;
		end
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("timeout with %0d results outstanding", awaited_results.size());
		$display("dedup_slot_allocator_tb failed");
		$finish;
	end

	initial begin : stimulus
		dsa_request_t fill_req;
		int           i;
		int           phase;

		for (i = 0; i < SLOTS; i++) begin
			model_keys[i]  = '0;
			model_stack[i] = SLOT_W'(i);
		end
		model_free      = SLOTS;
		model_enable    = 1'b1;
		sender_idle_pct = 35;

		// LIFO order after reset: grants come 1023, 1022, ...
		add_row(ROW_ENABLE_ON,  ACT_REGISTER, '0, '0, '0, RS_NEW);
		add_row(ROW_TYPED,   ACT_REGISTER, 64'd1, 10'd0, 10'd1023, RS_NEW);
		add_row(ROW_TYPED,   ACT_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0, 10'd1022, RS_NEW);
		add_row(ROW_TYPED,   ACT_REGISTER, 64'd1, 10'd0, 10'd1023, RS_HELD);
		add_row(ROW_TYPED,   ACT_REGISTER, 64'd0, 10'd1023, 10'd0, RS_REJECT);
		add_row(ROW_TYPED,   ACT_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1022, 10'd1022,
			RS_RELEASED);
		// second release of the same slot must not push it twice
		add_row(ROW_TYPED,   ACT_RELEASE, 64'd0, 10'd1022, 10'd0, RS_IGNORED);
		add_row(ROW_TYPED,   ACT_RELEASE, 64'd0, 10'd0, 10'd0, RS_IGNORED);
		// released slot comes straight back off the stack
		add_row(ROW_TYPED,   ACT_REGISTER, 64'h8000_0000_0000_0000, 10'd0, 10'd1022, RS_NEW);
		add_row(ROW_TYPED,   ACT_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0, 10'd1021, RS_NEW);
		add_row(ROW_PREDICT, ACT_REGISTER, 64'h5A5A_A5A5_0F0F_F0F0, 10'd1023, '0, RS_NEW);
		add_row(ROW_PREDICT, ACT_RELEASE, 64'd0, 10'd1023, '0, RS_NEW);
		add_row(ROW_TYPED,   ACT_REGISTER, 64'h8000_0000_0000_0000, 10'd0, 10'd1022, RS_HELD);
		// disabled: every action rejected, state untouched
		add_row(ROW_ENABLE_OFF, ACT_REGISTER, '0, '0, '0, RS_NEW);
		add_row(ROW_TYPED,   ACT_REGISTER, 64'd1, 10'd0, 10'd0, RS_REJECT);
		add_row(ROW_TYPED,   ACT_RELEASE, 64'd0, 10'd1021, 10'd0, RS_REJECT);
		add_row(ROW_ENABLE_ON,  ACT_REGISTER, '0, '0, '0, RS_NEW);
		add_row(ROW_PREDICT, ACT_RELEASE, 64'd0, 10'd1021, '0, RS_NEW);
		// fill every slot; slot 0 sits at the bottom of the stack and goes last
		add_row(ROW_FILL,    ACT_REGISTER, '0, '0, '0, RS_NEW);
		add_row(ROW_TYPED,   ACT_REGISTER, 64'h0123_4567_89AB_CDEF, 10'd0, 10'd0, RS_FULL);
		add_row(ROW_TYPED,   ACT_RELEASE, 64'd0, 10'd0, 10'd0, RS_RELEASED);
		add_row(ROW_TYPED,   ACT_REGISTER, 64'h0123_4567_89AB_CDEF, 10'd0, 10'd0, RS_NEW);
		add_row(ROW_TYPED,   ACT_REGISTER, 64'hFEDC_BA98_7654_3210, 10'd0, 10'd0, RS_FULL);
		add_row(ROW_TYPED,   ACT_RELEASE, 64'd0, 10'd512, 10'd512, RS_RELEASED);
		add_row(ROW_ENABLE_OFF, ACT_REGISTER, '0, '0, '0, RS_NEW);
		add_row(ROW_TYPED,   ACT_RELEASE, 64'd0, 10'd1023, 10'd0, RS_REJECT);
		add_row(ROW_ENABLE_ON,  ACT_REGISTER, '0, '0, '0, RS_NEW);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// the first enable write also waits out the clearing pass after reset
		foreach (stim_plan[n]) begin
			case (stim_plan[n].kind)
				ROW_ENABLE_ON:  write_enable(1'b1);
				ROW_ENABLE_OFF: write_enable(1'b0);
				ROW_TYPED:      issue_request(stim_plan[n].req, 1'b1, stim_plan[n].want);
				ROW_PREDICT:    issue_request(stim_plan[n].req, 1'b0, '0);
				ROW_FILL: begin
					while (model_free != 0) begin
						fill_req.action       = ACT_REGISTER;
						fill_req.resource_key = fresh_key();
						fill_req.release_slot = SLOT_W'($urandom_range(SLOTS - 1));
						issue_request(fill_req, 1'b0, '0);
					end
				end
			endcase
		end

		// random part starts from a nearly full table; releases open it up
		for (phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 76 : 0;
			if (phase == 1) begin
				write_enable(1'b0);
				repeat (12) issue_request(random_request(), 1'b0, '0);
				write_enable(1'b1);
			end
			repeat (RANDOM_PER_PHASE) issue_request(random_request(), 1'b0, '0);
		end

		drain_results();
		// any stray strobe after the last result still counts
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d requests, %0d results: %0d new, %0d held, %0d full, %0d rejected",
			requests_sent, results_checked, status_tally[RS_NEW], status_tally[RS_HELD],
			status_tally[RS_FULL], status_tally[RS_REJECT]);
		$display("%0d released, %0d ignored; table filled to capacity, enable toggled",
			status_tally[RS_RELEASED], status_tally[RS_IGNORED]);
		if (mismatch_count == 0 && awaited_results.size() == 0)
			$display("dedup_slot_allocator_tb passed");
		else
			$display("dedup_slot_allocator_tb failed");
		$finish;
	end

endmodule
